/* design/tkpq_pkg.sv */
// tkpq_pkg: shared types, codes and key compare for the two-key priority queue
// depends on nothing; imported by two_key_sorted_priority_queue_top
`default_nettype none

package tkpq_pkg;

    // default number of entries the queue can hold
    localparam int DEF_CAPACITY = 64;

    // field widths
    localparam int ID_W  = 16;
    localparam int KEY_W = 16;
    localparam int OCC_W = 7;
    localparam int STS_W = 2;

    // result status codes
    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // one stored entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] prio;
        logic [KEY_W-1:0] treat;
    } t_entry;

    // true if key of a is less than or equal to key of b
    function automatic logic key_le(input t_entry a, input t_entry b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio < b.prio);
        end else begin
            res = (a.treat <= b.treat);
        end
        return res;
    endfunction

endpackage : tkpq_pkg

`default_nettype wire

/* design/two_key_sorted_priority_queue_top.sv */
// two_key_sorted_priority_queue_top: bounded priority queue kept sorted in one memory
// depends on tkpq_pkg (types, status codes, key compare)
`default_nettype none

// Usage
//   Input channel (i_valid / o_ready) carries a command: push (id, prio, treat)
//   or pop. Output channel (o_valid / i_ready) returns one beat per command:
//   the head after the command, the popped id, the occupancy and a status.
//   Entries are held in a circular buffer in one memory (one write and one
//   registered read port), sorted by prio then treat; equal keys keep arrival
//   order. A pop moves the base pointer and reads the new head; no read
//   is made when the queue ends up empty or was empty. A push to an empty
//   or full queue goes straight to its result. Any other push walks down
//   from the tail one entry per cycle, moving each larger entry up one slot
//   (at most CAPACITY - 1 of them). The single memory read port sets this
//   walk rate. One command is in work at a time; a new one is taken once the
//   previous result sits in the output register, even if the receiver has not
//   yet taken it. When the receiver stalls, the result holds and the next
//   command waits in its final step until the output register frees up.
//   Reset (synchronous, active low) empties the queue; no clearing pass.
module two_key_sorted_priority_queue_top #(
    parameter int CAPACITY = tkpq_pkg::DEF_CAPACITY
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // command channel
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic                       i_cmd,
    input  wire logic [tkpq_pkg::ID_W-1:0]  i_entry_id,
    input  wire logic [tkpq_pkg::KEY_W-1:0] i_prio,
    input  wire logic [tkpq_pkg::KEY_W-1:0] i_treat,
    // result channel
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic                            o_head_valid,
    output logic [tkpq_pkg::ID_W-1:0]       o_head_id,
    output logic [tkpq_pkg::KEY_W-1:0]      o_head_prio,
    output logic [tkpq_pkg::KEY_W-1:0]      o_head_treat,
    output logic [tkpq_pkg::ID_W-1:0]       o_popped_id,
    output logic [tkpq_pkg::OCC_W-1:0]      o_occupancy,
    output logic [tkpq_pkg::STS_W-1:0]      o_status
);
    import tkpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_POPRD,
        ST_DONE
    } t_state;

    // logical index to physical address, wrapping at CAPACITY
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // entry memory and its registered read data
    t_entry r_mem [CAPACITY];
    t_entry r_rd;

    // control and working registers
    t_state         r_state, n_state;
    logic [CW-1:0]  r_fill, n_fill;
    logic [AW-1:0]  r_base, n_base;
    logic [AW-1:0]  r_idx, n_idx;
    t_entry         r_head, n_head;
    t_entry         r_new, n_new;
    t_status        r_status, n_status;
    logic [ID_W-1:0] r_popped, n_popped;

    // output register
    logic            r_ov, n_ov;
    logic            r_o_hv, n_o_hv;
    t_entry          r_o_head, n_o_head;
    logic [ID_W-1:0] r_o_popped, n_o_popped;
    logic [OCC_W-1:0] r_o_occ, n_o_occ;
    t_status         r_o_status, n_o_status;

    // memory port controls
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    t_entry         w_wdata;
    logic [AW-1:0]  w_raddr;

    t_entry         w_in;
    logic [31:0]    w_fill32;

    assign w_in     = '{id: i_entry_id, prio: i_prio, treat: i_treat};
    assign w_fill32 = 32'(r_fill);

    // next-state logic for the sequencer
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_base     = r_base;
        n_idx      = r_idx;
        n_head     = r_head;
        n_new      = r_new;
        n_status   = r_status;
        n_popped   = r_popped;
        n_ov       = r_ov;
        n_o_hv     = r_o_hv;
        n_o_head   = r_o_head;
        n_o_popped = r_o_popped;
        n_o_occ    = r_o_occ;
        n_o_status = r_o_status;
        w_we       = 1'b0;
        w_waddr    = r_base;
        w_wdata    = r_new;
        w_raddr    = r_base;

        // receiver takes the result beat
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_status = STS_OK;
                    n_popped = '0;
                    n_new    = w_in;
                    n_state  = ST_DONE;
                    if (i_cmd == CMD_PUSH) begin
                        if (r_fill == FULL_CNT) begin
                            n_status = STS_FULL;
                        end else if (r_fill == '0) begin
                            w_we    = 1'b1;
                            w_waddr = r_base;
                            w_wdata = w_in;
                            n_head  = w_in;
                            n_fill  = CW'(1);
                        end else begin
                            // start the walk down from the tail
                            n_idx   = AW'(r_fill - CW'(1));
                            w_raddr = phys(r_base, AW'(r_fill - CW'(1)));
                            n_state = ST_SCAN;
                        end
                    end else begin
                        if (r_fill == '0) begin
                            n_status = STS_EMPTY;
                        end else begin
                            n_popped = r_head.id;
                            n_base   = phys(r_base, AW'(1));
                            n_fill   = r_fill - CW'(1);
                            if (r_fill > CW'(1)) begin
                                w_raddr = phys(r_base, AW'(1));
                                n_state = ST_POPRD;
                            end
                        end
                    end
                end
            end
            ST_SCAN: begin
                w_we    = 1'b1;
                w_waddr = phys(r_base, r_idx + AW'(1));
                if (key_le(r_rd, r_new)) begin
                    // new entry lands right above this one
                    w_wdata = r_new;
                    n_fill  = r_fill + CW'(1);
                    n_state = ST_DONE;
                end else begin
                    // move this entry up one slot
                    w_wdata = r_rd;
                    if (r_idx == '0) begin
                        n_state = ST_PLACE;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        w_raddr = phys(r_base, r_idx - AW'(1));
                    end
                end
            end
            ST_PLACE: begin
                // new entry becomes the head
                w_we    = 1'b1;
                w_waddr = r_base;
                w_wdata = r_new;
                n_head  = r_new;
                n_fill  = r_fill + CW'(1);
                n_state = ST_DONE;
            end
            ST_POPRD: begin
                n_head  = r_rd;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov       = 1'b1;
                    n_o_hv     = (r_fill != '0);
                    n_o_head   = (r_fill != '0) ? r_head : '0;
                    n_o_popped = r_popped;
                    n_o_occ    = w_fill32[OCC_W-1:0];
                    n_o_status = r_status;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_base  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_base  <= n_base;
            r_ov    <= n_ov;
        end
        r_idx      <= n_idx;
        r_head     <= n_head;
        r_new      <= n_new;
        r_status   <= n_status;
        r_popped   <= n_popped;
        r_o_hv     <= n_o_hv;
        r_o_head   <= n_o_head;
        r_o_popped <= n_o_popped;
        r_o_occ    <= n_o_occ;
        r_o_status <= n_o_status;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    // port drive
    assign o_ready      = (r_state == ST_IDLE);
    assign o_valid      = r_ov;
    assign o_head_valid = r_o_hv;
    assign o_head_id    = r_o_head.id;
    assign o_head_prio  = r_o_head.prio;
    assign o_head_treat = r_o_head.treat;
    assign o_popped_id  = r_o_popped;
    assign o_occupancy  = r_o_occ;
    assign o_status     = r_o_status;

    // fill count never passes the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond capacity");

    // the walk only runs on a queue that is neither empty nor full
    a_scan_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_fill != '0 && r_fill != FULL_CNT))
        else $error("insert walk on empty or full queue");

    // a dropped push reports a nonempty queue
    a_full_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_FULL) |-> o_head_valid)
        else $error("full status with empty head");

    // a pop on empty reports no head and no popped id
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STS_EMPTY) |-> (!o_head_valid && o_popped_id == '0))
        else $error("empty pop reports data");

    // walk index stays inside the filled part
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CW'(r_idx) < r_fill))
        else $error("walk index outside filled entries");

endmodule : two_key_sorted_priority_queue_top

`default_nettype wire
